// File: sv/sorted_unique_list_table_assert.svh
// Assertion macros for the sorted unique list table checker.
// Needs signals named clock and reset in the scope of use.
`ifndef SORTED_UNIQUE_LIST_TABLE_ASSERT_SVH
`define SORTED_UNIQUE_LIST_TABLE_ASSERT_SVH

// same-cycle implication, off while reset is high
`define SULT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define SULT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/sult_pkg.sv
// Shared types and constants for the sorted unique list table.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
`timescale 1ns / 1ps

package sult_pkg;

   localparam int VALUE_W     = 64;
   localparam int ACTION_W    = 3;
   localparam int IDX_W       = 6;
   localparam int COUNT_OUT_W = 7;
   localparam int STATUS_W    = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT  = 3'd0,
      ACT_PREPEND = 3'd1,
      ACT_APPEND  = 3'd2,
      ACT_REMOVE  = 3'd3,
      ACT_READ    = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_DUP   = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   // how a cell decides that it sits at or after the target position
   typedef enum logic [1:0] {
      MODE_SORTED = 2'd0,
      MODE_FRONT  = 2'd1,
      MODE_BACK   = 2'd2,
      MODE_INDEX  = 2'd3
   } scan_mode_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_SCAN  = 2'd1,
      S_SHIFT = 2'd2,
      S_CHECK = 2'd3
   } seq_state_type;

   // command broadcast from the sequencer to every cell
   typedef struct packed {
      logic                scan_en;
      logic                ins_en;
      logic                rem_en;
      scan_mode_type       mode;
      logic [VALUE_W-1:0]  value;
      logic [IDX_W-1:0]    index;
   } cell_cmd_type;

endpackage

// File: sv/sult_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on sult_pkg for field widths.
`timescale 1ns / 1ps

interface sult_req_if;
   import sult_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [VALUE_W-1:0]  value;
   logic [IDX_W-1:0]           index;

   modport source (output valid, output action, output value, output index, input ready);
   modport sink   (input valid, input action, input value, input index, output ready);
endinterface

interface sult_rsp_if;
   import sult_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  read_value;
   logic [COUNT_OUT_W-1:0]     entry_count;
   logic                       is_sorted;
   logic [STATUS_W-1:0]        status;

   modport source (output valid, output read_value, output entry_count, output is_sorted,
                   output status, input ready);
   modport sink   (input valid, input read_value, input entry_count, input is_sorted,
                   input status, output ready);
endinterface

// File: sv/sult_cell.sv
// One slot of the list: holds an entry, finds its place in the scan, shifts.
// Depends on sult_pkg.
`timescale 1ns / 1ps

module sult_cell #(
   parameter int POS   = 0,
   parameter int CNT_W = 7
) (
   input  logic                           clock,
   input  sult_pkg::cell_cmd_type         cmd,
   input  logic [CNT_W-1:0]               count,
   input  logic                           chain_in,
   output logic                           chain_out,
   input  logic                           prev_mark,
   output logic                           mark_out,
   input  logic [sult_pkg::VALUE_W-1:0]   prev_entry,
   input  logic [sult_pkg::VALUE_W-1:0]   next_entry,
   output logic [sult_pkg::VALUE_W-1:0]   entry_out,
   output logic                           dup_hit,
   output logic [sult_pkg::VALUE_W-1:0]   read_data,
   output logic                           order_ok
);
   import sult_pkg::*;

   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam logic [CMP_W-1:0] POS_V = CMP_W'(POS);

   logic [VALUE_W-1:0] entry_ff, entry_in;
   logic               entry_we;
   logic               mark_ff;
   logic [CMP_W-1:0]   count_ext, idx_ext;
   logic               valid, ge, eq, local_mark, first_scan, first_shift;

   assign count_ext = CMP_W'(count);
   assign idx_ext   = CMP_W'(cmd.index);
   assign valid     = POS_V < count_ext;
   assign ge        = $signed(entry_ff) >= $signed(cmd.value);
   assign eq        = entry_ff == cmd.value;

   always_comb begin
      case (cmd.mode)
         MODE_SORTED: local_mark = (valid & ge) | ~valid;
         MODE_FRONT:  local_mark = 1'b1;
         MODE_BACK:   local_mark = ~valid;
         MODE_INDEX:  local_mark = POS_V >= idx_ext;
         default:     local_mark = 1'b0;
      endcase
   end

   // prefix carry: once a cell marks, every later cell is at or after the spot
   assign chain_out  = chain_in | local_mark;
   assign first_scan = chain_out & ~chain_in;
   assign dup_hit    = (cmd.mode == MODE_SORTED) & first_scan & valid & eq;

   assign first_shift = mark_ff & ~prev_mark;

   always_comb begin
      entry_we = 1'b0;
      entry_in = entry_ff;
      if (cmd.ins_en && mark_ff) begin
         entry_we = 1'b1;
         entry_in = first_shift ? cmd.value : prev_entry;
      end else if (cmd.rem_en && mark_ff) begin
         entry_we = 1'b1;
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_en) begin
         mark_ff <= chain_out;
      end
      if (entry_we) begin
         entry_ff <= entry_in;
      end
   end

   assign mark_out  = mark_ff;
   assign entry_out = entry_ff;
   assign read_data = (valid && (POS_V == idx_ext)) ? entry_ff : '0;

   if (POS == 0) begin : g_head
      assign order_ok = 1'b1;
   end else begin : g_body
      assign order_ok = ~valid | ($signed(entry_ff) > $signed(prev_entry));
   end

endmodule

// File: sv/sorted_unique_list_table.sv
// Sorted unique list table: a row of CAPACITY cells holding signed 64-bit entries.
// Depends on sult_pkg, sult_if (sult_req_if, sult_rsp_if) and sult_cell.
//
// Usage
//   req_chan carries one request word: action, value, index. It is taken at a
//   clock edge where valid and ready are both high.
//   rsp_chan returns exactly one response word per request: read_value,
//   entry_count, is_sorted, status, in request order.
// Timing
//   The response is loaded into the output register as the order check
//   ends. Each request passes a scan state across the cell row, a shift
//   state that updates it, and an order-check state over the updated row.
//   Requests do not overlap: req_chan.ready is high only while idle.
// Stall
//   The response sits in an output register. A new request is taken while
//   it waits; the order check then holds until the register frees up.
// Reset
//   Synchronous, active high. Clears the entry count, the sequencer and the
//   response valid. Entry contents are not cleared; only slots below the
//   count are ever read.
`timescale 1ns / 1ps

module sorted_unique_list_table #(
   parameter int CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   sult_req_if.sink          req_chan,
   sult_rsp_if.source        rsp_chan
);
   import sult_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam logic [CMP_W-1:0] CAP_V = CMP_W'(CAPACITY);

   // sequencer
   seq_state_type state_ff, state_in;
   logic          req_ready, accept;
   logic          rsp_load, rsp_slot_free;

   // latched request
   action_type          act_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [IDX_W-1:0]    index_ff;

   // scan results
   logic                dup_ff;
   logic [VALUE_W-1:0]  rd_ff;

   // list state and staged result
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                count_we;
   status_type          res_status_ff, res_status_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]      rsp_value_ff;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff;
   logic                    rsp_sorted_ff;
   status_type              rsp_status_ff;

   cell_cmd_type        cmd;
   logic                ins_go, rem_go;
   logic [CMP_W-1:0]    count_ext, idx_ext;
   logic                full, in_range;

   // cell row wiring
   logic [CAPACITY:0]   chain_w;
   logic [CAPACITY-1:0] mark_w, prev_mark_w, dup_w, ok_w;
   logic [VALUE_W-1:0]  entry_w [CAPACITY];
   logic [VALUE_W-1:0]  prev_e_w [CAPACITY];
   logic [VALUE_W-1:0]  next_e_w [CAPACITY];
   logic [VALUE_W-1:0]  rd_w [CAPACITY];
   logic [VALUE_W-1:0]  rd_any;

   assign chain_w[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_mark_w[i] = 1'b0;
         assign prev_e_w[i]    = value_ff;
      end else begin : g_mid
         assign prev_mark_w[i] = mark_w[i-1];
         assign prev_e_w[i]    = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_e_w[i] = entry_w[i];
      end else begin : g_more
         assign next_e_w[i] = entry_w[i+1];
      end

      sult_cell #(
         .POS   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .chain_in   (chain_w[i]),
         .chain_out  (chain_w[i+1]),
         .prev_mark  (prev_mark_w[i]),
         .mark_out   (mark_w[i]),
         .prev_entry (prev_e_w[i]),
         .next_entry (next_e_w[i]),
         .entry_out  (entry_w[i]),
         .dup_hit    (dup_w[i]),
         .read_data  (rd_w[i]),
         .order_ok   (ok_w[i])
      );
   end

   // at most one cell drives a nonzero read word
   always_comb begin
      rd_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_any = rd_any | rd_w[i];
      end
   end

   assign count_ext = CMP_W'(count_ff);
   assign idx_ext   = CMP_W'(index_ff);
   assign full      = count_ext >= CAP_V;
   assign in_range  = idx_ext < count_ext;

   assign rsp_slot_free = ~rsp_valid_ff | rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_chan.valid) state_in = S_SCAN;
         S_SCAN:  state_in = S_SHIFT;
         S_SHIFT: state_in = S_CHECK;
         S_CHECK: if (rsp_slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_CHECK: rsp_load  = rsp_slot_free;
         default: ;
      endcase
   end

   assign accept = req_chan.valid & req_ready;

   // decide the action once the scan result is in
   always_comb begin
      ins_go        = 1'b0;
      rem_go        = 1'b0;
      res_status_in = STATUS_DONE;
      res_value_in  = '0;
      case (act_ff)
         ACT_INSERT: begin
            if (dup_ff)    res_status_in = STATUS_DUP;
            else if (full) res_status_in = STATUS_FULL;
            else           ins_go = 1'b1;
         end
         ACT_PREPEND, ACT_APPEND: begin
            if (full) res_status_in = STATUS_FULL;
            else      ins_go = 1'b1;
         end
         ACT_REMOVE: begin
            if (in_range) rem_go = 1'b1;
            else          res_status_in = STATUS_RANGE;
         end
         ACT_READ: begin
            if (in_range) res_value_in  = rd_ff;
            else          res_status_in = STATUS_RANGE;
         end
         default: ;   // unused action codes change nothing
      endcase
   end

   always_comb begin
      cmd.scan_en = state_ff == S_SCAN;
      cmd.ins_en  = (state_ff == S_SHIFT) & ins_go;
      cmd.rem_en  = (state_ff == S_SHIFT) & rem_go;
      cmd.value   = value_ff;
      cmd.index   = index_ff;
      case (act_ff)
         ACT_INSERT:  cmd.mode = MODE_SORTED;
         ACT_PREPEND: cmd.mode = MODE_FRONT;
         ACT_APPEND:  cmd.mode = MODE_BACK;
         default:     cmd.mode = MODE_INDEX;
      endcase
   end

   always_comb begin
      count_we = (state_ff == S_SHIFT) & (ins_go | rem_go);
      count_in = ins_go ? count_ff + CNT_W'(1) : count_ff - CNT_W'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)            rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (count_we) begin
            count_ff <= count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= action_type'(req_chan.action);
         value_ff <= req_chan.value;
         index_ff <= req_chan.index;
      end
      if (state_ff == S_SCAN) begin
         dup_ff <= |dup_w;
         rd_ff  <= rd_any;
      end
      if (state_ff == S_SHIFT) begin
         res_status_ff <= res_status_in;
         res_value_ff  <= res_value_in;
      end
      if (rsp_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_count_ff  <= COUNT_OUT_W'(count_ff);
         rsp_sorted_ff <= &ok_w;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.is_sorted   = rsp_sorted_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

// File: sv/sult_checker.sv
// Port-level checks for sorted_unique_list_table, attached by bind.
// Depends on sult_pkg and sorted_unique_list_table_assert.svh.
`timescale 1ns / 1ps
`include "sorted_unique_list_table_assert.svh"

module sult_checker #(
   parameter int CAPACITY = 64
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [sult_pkg::VALUE_W-1:0]        rsp_read_value,
   input logic [sult_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   input logic                                rsp_is_sorted,
   input logic [sult_pkg::STATUS_W-1:0]       rsp_status
);
   import sult_pkg::*;

   // a response word stays up until taken
   `SULT_ASSERT_NEXT(a_rsp_hold, (rsp_valid && !rsp_ready), (rsp_valid),
                     "response dropped before taken")

   // one request in process at a time: the table is busy right after taking one
   `SULT_ASSERT_NEXT(a_busy_after_take, (req_valid && req_ready), (!req_ready),
                     "request taken while busy")

   // a full report means the count sits at capacity
   `SULT_ASSERT_IMPLY(a_full_count, (rsp_valid && (rsp_status == STATUS_FULL)),
                      (rsp_entry_count == COUNT_OUT_W'(CAPACITY)),
                      "full status with count below capacity")

   // an empty or single-entry list is always in order
   `SULT_ASSERT_IMPLY(a_short_sorted,
                      ((CAPACITY < 128) && rsp_valid && (rsp_entry_count <= 7'd1)),
                      (rsp_is_sorted), "short list reported out of order")

   // only a good read returns data
   `SULT_ASSERT_IMPLY(a_read_status, (rsp_valid && (rsp_read_value != '0)),
                      (rsp_status == STATUS_DONE), "read data with error status")

endmodule

bind sorted_unique_list_table sult_checker #(
   .CAPACITY (CAPACITY)
) u_sult_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_read_value  (rsp_chan.read_value),
   .rsp_entry_count (rsp_chan.entry_count),
   .rsp_is_sorted   (rsp_chan.is_sorted),
   .rsp_status      (rsp_chan.status)
);
